// ===== rtl/core/qsu_pkg.sv =====
// ----------------------------------------------------------------------------
// qsu_pkg: shared types and constants for the quoted string unescaper
// State codes, status codes, character constants and inter-module bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package qsu_pkg;

    typedef enum logic [2:0] {
        MODE_WAIT = 3'd0,
        MODE_BODY = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_SKIP = 3'd3,
        MODE_DIG  = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        KIND_OCT = 2'd0,
        KIND_X   = 2'd1,
        KIND_U4  = 2'd2,
        KIND_U8  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_BUSY   = 2'd0,
        STAT_DONE   = 2'd1,
        STAT_UNTERM = 2'd2
    } status_t;

    localparam int CH_W      = 21;
    localparam int CHAR_W    = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW   = $clog2(FIFO_DEPTH);

    // input characters
    localparam logic [CH_W-1:0] CH_QUOTE  = 21'h22;
    localparam logic [CH_W-1:0] CH_BSLASH = 21'h5c;
    localparam logic [CH_W-1:0] CH_NL     = 21'h0a;
    localparam logic [CH_W-1:0] CH_SPACE  = 21'h20;
    localparam logic [CH_W-1:0] CH_TAB    = 21'h09;
    localparam logic [CH_W-1:0] CH_A_LC   = 21'h61;
    localparam logic [CH_W-1:0] CH_B_LC   = 21'h62;
    localparam logic [CH_W-1:0] CH_F_LC   = 21'h66;
    localparam logic [CH_W-1:0] CH_N_LC   = 21'h6e;
    localparam logic [CH_W-1:0] CH_R_LC   = 21'h72;
    localparam logic [CH_W-1:0] CH_T_LC   = 21'h74;
    localparam logic [CH_W-1:0] CH_V_LC   = 21'h76;
    localparam logic [CH_W-1:0] CH_X_LC   = 21'h78;
    localparam logic [CH_W-1:0] CH_U_LC   = 21'h75;
    localparam logic [CH_W-1:0] CH_U_UC   = 21'h55;
    localparam logic [CH_W-1:0] CH_DIG0   = 21'h30;
    localparam logic [CH_W-1:0] CH_DIG7   = 21'h37;
    localparam logic [CH_W-1:0] CH_DIG9   = 21'h39;
    localparam logic [CH_W-1:0] CH_A_UC   = 21'h41;
    localparam logic [CH_W-1:0] CH_F_UC   = 21'h46;

    // decoded characters
    localparam logic [CHAR_W-1:0] OUT_BEL    = 32'h7;
    localparam logic [CHAR_W-1:0] OUT_BS     = 32'h8;
    localparam logic [CHAR_W-1:0] OUT_FF     = 32'hc;
    localparam logic [CHAR_W-1:0] OUT_LF     = 32'ha;
    localparam logic [CHAR_W-1:0] OUT_CR     = 32'hd;
    localparam logic [CHAR_W-1:0] OUT_HT     = 32'h9;
    localparam logic [CHAR_W-1:0] OUT_VT     = 32'hb;
    localparam logic [CHAR_W-1:0] OUT_SPACE  = 32'h20;
    localparam logic [CHAR_W-1:0] OUT_BSLASH = 32'h5c;
    localparam logic [CHAR_W-1:0] OUT_X_LC   = 32'h78;
    localparam logic [CHAR_W-1:0] OUT_U_LC   = 32'h75;
    localparam logic [CHAR_W-1:0] OUT_U_UC   = 32'h55;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              char_valid;
        status_t           status;
        logic              last_of_run;
    } result_t;

    // results of one character, written to the queue together
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

`default_nettype wire

// ===== rtl/core/qsu_in_if.sv =====
// ----------------------------------------------------------------------------
// qsu_in_if: character input channel
// Valid/ready channel carrying one code point and its end-of-input flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface qsu_in_if
    import qsu_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            final_char;

    modport source (output valid, output ch, output final_char, input ready);
    modport sink   (input valid, input ch, input final_char, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/qsu_out_if.sv =====
// ----------------------------------------------------------------------------
// qsu_out_if: result output channel
// Valid/ready channel carrying one decoded character with status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface qsu_out_if
    import qsu_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              char_valid;
    logic [1:0]        status;
    logic              last_of_run;

    modport source (output valid, output out_char, output char_valid, output status,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_char, input char_valid, input status,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/qsu_step.sv =====
// ----------------------------------------------------------------------------
// qsu_step: input register and per-character decode
// Holds one character, decodes it against the escape state and produces
// zero to two results per beat for the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module qsu_step
    import qsu_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [CH_W-1:0] in_ch,
    input  wire logic            in_final,
    input  wire logic            room,
    output push_t                push
);

    typedef struct packed {
        logic [1:0]        n;
        logic [CHAR_W-1:0] e0;
        logic [CHAR_W-1:0] e1;
    } slots_t;

    function automatic slots_t add(slots_t s, logic [CHAR_W-1:0] v);
        slots_t r;
        r = s;
        if (s.n == 2'd0)
            r.e0 = v;
        else
            r.e1 = v;
        r.n = s.n + 2'd1;
        return r;
    endfunction

    logic            stage_valid_reg;
    logic [CH_W-1:0] ch_reg;
    logic            fin_reg;

    mode_t             mode_reg, mode_next;
    kind_t             kind_reg, kind_next;
    logic [CHAR_W-1:0] acc_reg, acc_next;
    logic [3:0]        cnt_reg, cnt_next;

    logic              adv;
    logic              is_dec, is_oct, is_lc, is_uc, dig_ok;
    logic [3:0]        dval;
    logic [CHAR_W-1:0] acc_dig;
    logic [3:0]        cnt_inc;
    logic              lim_hit;
    logic              body;
    slots_t            sl;
    status_t           rs;
    logic [CHAR_W-1:0] ch_ext;

    assign adv      = stage_valid_reg && room;
    assign in_ready = !stage_valid_reg || room;
    assign ch_ext   = {{(CHAR_W - CH_W){1'b0}}, ch_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ch_reg  <= in_ch;
            fin_reg <= in_final;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_WAIT;
            kind_reg <= KIND_OCT;
            acc_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (adv)
        begin
            mode_reg <= mode_next;
            kind_reg <= kind_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
        end
    end

    // digit classification for the current escape kind
    assign is_dec = (ch_reg >= CH_DIG0) && (ch_reg <= CH_DIG9);
    assign is_oct = (ch_reg >= CH_DIG0) && (ch_reg <= CH_DIG7);
    assign is_lc  = (ch_reg >= CH_A_LC) && (ch_reg <= CH_F_LC);
    assign is_uc  = (ch_reg >= CH_A_UC) && (ch_reg <= CH_F_UC);
    assign dig_ok = (kind_reg == KIND_OCT) ? is_oct : (is_dec || is_lc || is_uc);
    assign dval   = is_dec ? ch_reg[3:0] : ch_reg[3:0] + 4'd9;
    assign cnt_inc = (cnt_reg == 4'hf) ? cnt_reg : cnt_reg + 4'd1;

    always_comb
    begin
        acc_dig = '0;
        lim_hit = 1'b0;
        unique case (kind_reg)
            KIND_OCT:
            begin
                acc_dig = {23'd0, acc_reg[5:0], dval[2:0]};
                lim_hit = (cnt_inc >= 4'd3);
            end
            KIND_X:
            begin
                acc_dig = {24'd0, acc_reg[3:0], dval};
                lim_hit = 1'b0;
            end
            KIND_U4:
            begin
                acc_dig = {acc_reg[CHAR_W-5:0], dval};
                lim_hit = (cnt_inc >= 4'd4);
            end
            KIND_U8:
            begin
                acc_dig = {acc_reg[CHAR_W-5:0], dval};
                lim_hit = (cnt_inc >= 4'd8);
            end
            default:
            begin
                acc_dig = '0;
                lim_hit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        mode_next = mode_reg;
        kind_next = kind_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        sl        = '0;
        rs        = STAT_BUSY;
        body      = 1'b0;

        unique case (mode_reg)
            MODE_BODY:
            begin
                body = 1'b1;
            end
            MODE_SKIP:
            begin
                if (ch_reg != CH_SPACE && ch_reg != CH_TAB)
                begin
                    mode_next = MODE_BODY;
                    body      = 1'b1;
                end
            end
            MODE_ESC:
            begin
                mode_next = MODE_BODY;
                if (ch_reg == CH_A_LC)
                    sl = add(sl, OUT_BEL);
                else if (ch_reg == CH_B_LC)
                    sl = add(sl, OUT_BS);
                else if (ch_reg == CH_F_LC)
                    sl = add(sl, OUT_FF);
                else if (ch_reg == CH_N_LC)
                    sl = add(sl, OUT_LF);
                else if (ch_reg == CH_R_LC)
                    sl = add(sl, OUT_CR);
                else if (ch_reg == CH_T_LC)
                    sl = add(sl, OUT_HT);
                else if (ch_reg == CH_V_LC)
                    sl = add(sl, OUT_VT);
                else if (ch_reg == CH_NL)
                begin
                    sl        = add(sl, OUT_SPACE);
                    mode_next = MODE_SKIP;
                end
                else if (ch_reg == CH_X_LC || ch_reg == CH_U_LC || ch_reg == CH_U_UC)
                begin
                    mode_next = MODE_DIG;
                    acc_next  = '0;
                    cnt_next  = '0;
                    if (ch_reg == CH_X_LC)
                        kind_next = KIND_X;
                    else if (ch_reg == CH_U_LC)
                        kind_next = KIND_U4;
                    else
                        kind_next = KIND_U8;
                end
                else if (is_oct)
                begin
                    mode_next = MODE_DIG;
                    kind_next = KIND_OCT;
                    acc_next  = {29'd0, ch_reg[2:0]};
                    cnt_next  = 4'd1;
                end
                else
                    sl = add(sl, ch_ext);
            end
            MODE_DIG:
            begin
                if (!dig_ok)
                begin
                    // terminator: emit value, then treat it as a body char
                    sl        = add(sl, acc_reg);
                    mode_next = MODE_BODY;
                    body      = 1'b1;
                end
                else if (lim_hit)
                begin
                    sl        = add(sl, acc_dig);
                    mode_next = MODE_BODY;
                    acc_next  = '0;
                    cnt_next  = '0;
                end
                else
                begin
                    acc_next = acc_dig;
                    cnt_next = cnt_inc;
                end
            end
            default:
            begin
                mode_next = (ch_reg == CH_QUOTE) ? MODE_BODY : MODE_WAIT;
            end
        endcase

        if (body)
        begin
            if (ch_reg == CH_QUOTE)
            begin
                rs        = STAT_DONE;
                mode_next = MODE_WAIT;
            end
            else if (ch_reg == CH_BSLASH)
                mode_next = MODE_ESC;
            else
                sl = add(sl, ch_ext);
        end

        // end of input without a closing quote: flush pending escape
        if (fin_reg && rs != STAT_DONE)
        begin
            if (mode_next == MODE_ESC)
                sl = add(sl, OUT_BSLASH);
            else if (mode_next == MODE_DIG)
            begin
                if (cnt_next != 4'd0 || kind_next == KIND_OCT)
                    sl = add(sl, acc_next);
                else if (kind_next == KIND_X)
                    sl = add(sl, OUT_X_LC);
                else if (kind_next == KIND_U4)
                    sl = add(sl, OUT_U_LC);
                else
                    sl = add(sl, OUT_U_UC);
            end
            rs        = STAT_UNTERM;
            mode_next = MODE_WAIT;
            kind_next = KIND_OCT;
            acc_next  = '0;
            cnt_next  = '0;
        end
    end

    always_comb
    begin
        push = '0;
        if (adv)
        begin
            push.cnt = (sl.n == 2'd0 && rs != STAT_BUSY) ? 2'd1 : sl.n;
        end
        push.r0.out_char    = (sl.n != 2'd0) ? sl.e0 : '0;
        push.r0.char_valid  = (sl.n != 2'd0);
        push.r0.last_of_run = (sl.n != 2'd2);
        push.r0.status      = (sl.n != 2'd2) ? rs : STAT_BUSY;
        push.r1.out_char    = sl.e1;
        push.r1.char_valid  = 1'b1;
        push.r1.last_of_run = 1'b1;
        push.r1.status      = rs;
    end

`ifndef SYNTH
    // end of input returns the mode to waiting; a closing quote leaves the digit state as it was
    a_fin_returns_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && fin_reg) |=> (mode_reg == MODE_WAIT))
        else $error("mode not back to waiting after end of input");

    a_no_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!stage_valid_reg || !room) |-> (push.cnt == 2'd0))
        else $error("push without a held character or room");

    a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt == 2'd2) |-> (push.r0.char_valid && push.r0.status == STAT_BUSY
                                && !push.r0.last_of_run))
        else $error("status on a non-final result");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/qsu_result_fifo.sv =====
// ----------------------------------------------------------------------------
// qsu_result_fifo: result queue
// Takes up to two results per cycle while room is high and presents one beat per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module qsu_result_fifo
    import qsu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    output logic       room,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    out_data
);

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    result_t             mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                pop;

    // room for a two-result beat
    assign room      = (count_reg <= CW'(FIFO_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + CW'(push.cnt) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2)
        begin
            mem[wr_ptr_reg + FIFO_AW'(1)] <= push.r1;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt != 2'd0) |-> room)
        else $error("result queue written without room");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(FIFO_DEPTH))
        else $error("result queue count out of range");

    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push.cnt == 2'd0) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("result queue count did not follow a pop");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/quoted_string_unescaper_unit.sv =====
// ----------------------------------------------------------------------------
// quoted_string_unescaper_unit: streaming decoder for a quoted literal
// Usage:
//   chars   - one code point per beat with final_char marking end of input.
//             The first quote opens the literal; text before it is dropped.
//   results - decoded characters, one per beat. A character gives zero, one
//             or two result beats; last_of_run marks the final one and a
//             nonzero status (done or unterminated) rides only on it.
// Path: the input register holds each character while it is decoded.
// Throughput: one character per cycle while results.ready is high and each
//   gives at most one result; a character that gives two results takes two
//   result beats. The four-entry result queue bounds decode-to-output slack.
// Stall: when results.ready is low the queue fills; with a character held,
//   chars.ready drops once fewer than two entries are free, and the held
//   character waits in the input register. Nothing is lost or repeated.
// Reset: rst_n clears the escape state to waiting for the opening quote and
//   empties the input register and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_string_unescaper_unit
    import qsu_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    qsu_in_if.sink   chars,
    qsu_out_if.source results
);

    push_t   push;
    logic    room;
    result_t res;

    qsu_step u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chars.valid),
        .in_ready (chars.ready),
        .in_ch    (chars.ch),
        .in_final (chars.final_char),
        .room     (room),
        .push     (push)
    );

    qsu_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_data  (res)
    );

    assign results.out_char    = res.out_char;
    assign results.char_valid  = res.char_valid;
    assign results.status      = res.status;
    assign results.last_of_run = res.last_of_run;

endmodule

`default_nettype wire
